@@ rtl/hsd_pkg.sv @@
// ----------------------------------------------------------------------------
// hsd_pkg: shared types for the huffman stream decoder
// Stream phases and the node store entry layout.
// ----------------------------------------------------------------------------
package hsd_pkg;

   localparam int NODE_IW = 9;   // node index width
   localparam int SYM_W   = 8;   // symbol width

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TREE,
      PH_DATA,
      PH_DONE,
      PH_BAD
   } phase_type;

   typedef struct packed {
      logic                 leaf;
      logic [SYM_W-1:0]     sym;
      logic [NODE_IW-1:0]   left;
      logic [NODE_IW-1:0]   right;
   } node_type;

   localparam int NODE_W = $bits(node_type);

endpackage

@@ rtl/hsd_ram.sv @@
// ----------------------------------------------------------------------------
// hsd_ram: generic single write, single read ram
// One write port, one read port with registered read data held between reads.
// ----------------------------------------------------------------------------
module hsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

@@ rtl/huffman_stream_decoder.sv @@
// ----------------------------------------------------------------------------
// huffman_stream_decoder: static huffman decoder over a byte alphabet
// Parses header, rebuilds the code tree and walks it bit by bit.
// ----------------------------------------------------------------------------
// A header beat (the first eight beats of a stream) is taken while the decoder
// stays idle; a bad alphabet size sends out the malformed beat after it.
// A tree or code beat is shifted out bit by bit after its accept cycle: a tree
// bit in S_BIT, a merge bit also through S_MERGE (stack ram read), a code bit
// also through S_WALK (registered node store read; not for a one-leaf tree),
// then S_FLUSH closes the beat and hands out the held symbol. Once the stream
// has ended or gone bad a beat goes straight to S_FLUSH; a bad tree bit cuts
// it short, and the result side can stall it. No new beat is taken before the
// last is through. Results of one beat leave in order, the final one with last
// set; a bad header or tree gives a single malformed result, symbol 0.
module huffman_stream_decoder #(
   parameter int MAX_SYMBOLS = 256
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_stream_start,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_symbol,
   output logic       rsp_last,
   output logic       rsp_malformed
);

   localparam int NODE_DEPTH = 2 * MAX_SYMBOLS - 1;
   localparam int NAW        = $clog2(NODE_DEPTH);
   localparam int SAW        = $clog2(MAX_SYMBOLS);
   localparam int IW         = hsd_pkg::NODE_IW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_BIT,
      S_MERGE,
      S_WALK,
      S_FLUSH,
      S_BAD
   } state_type;

   state_type           state_ff;
   hsd_pkg::phase_type  phase_ff;
   logic [2:0]          hdr_cnt_ff;
   logic [8:0]          alpha_ff;
   logic [31:0]         bits_rem_ff;
   logic [8:0]          leaves_ff;
   logic [3:0]          leaf_pend_ff;
   logic [7:0]          leaf_shift_ff;
   logic [IW-1:0]       node_cnt_ff;
   logic [8:0]          depth_ff;
   logic [IW-1:0]       top_ff;       // top of stack, the rest lives in ram
   hsd_pkg::node_type   root_ff;
   hsd_pkg::node_type   cur_ff;       // contents of the walk node
   logic [7:0]          byte_ff;
   logic [3:0]          bit_cnt_ff;
   logic                pend_valid_ff; // held result, last unknown yet
   logic [7:0]          pend_sym_ff;
   logic                rsp_valid_ff;
   logic [7:0]          rsp_symbol_ff;
   logic                rsp_last_ff;
   logic                rsp_malformed_ff;

   // ram ports
   logic                node_we, node_re;
   logic [NAW-1:0]      node_raddr;
   hsd_pkg::node_type   node_wdata;
   logic [hsd_pkg::NODE_W-1:0] node_rdata;
   hsd_pkg::node_type   nv;
   logic                stk_we, stk_re;
   logic [SAW-1:0]      stk_waddr, stk_raddr;
   logic [IW-1:0]       stk_rdata;

   // header byte
   logic [2:0]          hc_eff;
   logic [8:0]          alpha_eff;
   logic [16:0]         alpha_wide;
   logic [8:0]          hdr_alpha_in;
   logic [31:0]         hdr_bits_in;
   logic [2:0]          hdr_cnt_in;

   logic                bit_w;
   logic                rsp_free;
   logic [8:0]          depth_m1, depth_m2;
   logic [7:0]          leaf_sym;
   logic [IW-1:0]       next_idx;
   logic [31:0]         bits_dec;

   assign bit_w    = byte_ff[7];
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign depth_m1 = depth_ff - 9'd1;
   assign depth_m2 = depth_ff - 9'd2;
   assign leaf_sym = {leaf_shift_ff[6:0], bit_w};
   assign next_idx = bit_w ? cur_ff.right : cur_ff.left;
   assign bits_dec = bits_rem_ff - 32'd1;
   assign nv       = hsd_pkg::node_type'(node_rdata);

   always_comb begin
      hc_eff     = req_stream_start ? 3'd0 : hdr_cnt_ff;
      alpha_eff  = req_stream_start ? 9'd0 : alpha_ff;
      alpha_wide = {alpha_eff, req_data_byte};
      hdr_alpha_in = alpha_eff;
      hdr_bits_in  = req_stream_start ? 32'd0 : bits_rem_ff;
      if (hc_eff < 3'd4) begin
         hdr_alpha_in = (alpha_wide > 17'(MAX_SYMBOLS)) ? 9'(MAX_SYMBOLS + 1)
                                                       : alpha_wide[8:0];
      end else begin
         hdr_bits_in = {hdr_bits_in[23:0], req_data_byte};
      end
      hdr_cnt_in = hc_eff + 3'd1;
   end

   // ram control: leaf push, merge push, walk read, merge read
   always_comb begin
      node_we    = 1'b0;
      node_wdata = '0;
      node_re    = 1'b0;
      node_raddr = next_idx[NAW-1:0];
      stk_we     = 1'b0;
      stk_waddr  = depth_m1[SAW-1:0];
      stk_re     = 1'b0;
      stk_raddr  = depth_m2[SAW-1:0];
      if (state_ff == S_BIT && bit_cnt_ff != 4'd0) begin
         if (phase_ff == hsd_pkg::PH_TREE) begin
            if (leaf_pend_ff == 4'd1) begin
               node_we         = 1'b1;
               node_wdata.leaf = 1'b1;
               node_wdata.sym  = leaf_sym;
               stk_we          = (depth_ff != 9'd0);
            end else if (leaf_pend_ff == 4'd0 && !bit_w && depth_ff >= 9'd2) begin
               stk_re = 1'b1;
            end
         end else if (phase_ff == hsd_pkg::PH_DATA && !root_ff.leaf) begin
            node_re = 1'b1;
         end
      end else if (state_ff == S_MERGE) begin
         node_we          = 1'b1;
         node_wdata.left  = stk_rdata;
         node_wdata.right = top_ff;
      end
   end

   hsd_ram #(
      .WIDTH(hsd_pkg::NODE_W),
      .DEPTH(NODE_DEPTH)
   ) u_node_ram (
      .clock(clock),
      .we   (node_we),
      .waddr(node_cnt_ff[NAW-1:0]),
      .wdata(node_wdata),
      .re   (node_re),
      .raddr(node_raddr),
      .rdata(node_rdata)
   );

   hsd_ram #(
      .WIDTH(IW),
      .DEPTH(MAX_SYMBOLS)
   ) u_stack_ram (
      .clock(clock),
      .we   (stk_we),
      .waddr(stk_waddr),
      .wdata(top_ff),
      .re   (stk_re),
      .raddr(stk_raddr),
      .rdata(stk_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= hsd_pkg::PH_HEADER;
         hdr_cnt_ff    <= '0;
         alpha_ff      <= '0;
         bits_rem_ff   <= '0;
         leaves_ff     <= '0;
         leaf_pend_ff  <= '0;
         leaf_shift_ff <= '0;
         node_cnt_ff   <= '0;
         depth_ff      <= '0;
         top_ff        <= '0;
         root_ff       <= '0;
         cur_ff        <= '0;
         bit_cnt_ff    <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  if (req_stream_start || phase_ff == hsd_pkg::PH_HEADER) begin
                     alpha_ff    <= hdr_alpha_in;
                     bits_rem_ff <= hdr_bits_in;
                     hdr_cnt_ff  <= hdr_cnt_in;
                     phase_ff    <= hsd_pkg::PH_HEADER;
                     if (hdr_cnt_in == 3'd4 && (hdr_alpha_in == 9'd0 ||
                         hdr_alpha_in > 9'(MAX_SYMBOLS))) begin
                        phase_ff <= hsd_pkg::PH_BAD;
                        state_ff <= S_BAD;
                     end else if (hdr_cnt_in == 3'd0) begin
                        // eighth header beat wrapped the count
                        phase_ff      <= hsd_pkg::PH_TREE;
                        leaves_ff     <= '0;
                        leaf_pend_ff  <= '0;
                        leaf_shift_ff <= '0;
                        node_cnt_ff   <= '0;
                        depth_ff      <= '0;
                        top_ff        <= '0;
                        root_ff       <= '0;
                        cur_ff        <= '0;
                     end
                  end else begin
                     byte_ff    <= req_data_byte;
                     bit_cnt_ff <= 4'd8;
                     state_ff   <= S_BIT;
                  end
               end
            end
            S_BIT: begin
               if (bit_cnt_ff == 4'd0) begin
                  state_ff <= S_FLUSH;
               end else begin
                  unique case (phase_ff)
                     hsd_pkg::PH_TREE: begin
                        if (leaf_pend_ff != 4'd0) begin
                           leaf_shift_ff <= leaf_sym;
                           leaf_pend_ff  <= leaf_pend_ff - 4'd1;
                           if (leaf_pend_ff == 4'd1) begin
                              leaves_ff        <= leaves_ff + 9'd1;
                              top_ff           <= node_cnt_ff;
                              depth_ff         <= depth_ff + 9'd1;
                              node_cnt_ff      <= node_cnt_ff + IW'(1);
                              root_ff          <= node_wdata;
                              cur_ff           <= node_wdata;
                              if (leaves_ff + 9'd1 == alpha_ff && depth_ff == 9'd0) begin
                                 phase_ff <= (bits_rem_ff == 32'd0) ? hsd_pkg::PH_DONE
                                                                    : hsd_pkg::PH_DATA;
                              end
                           end
                           byte_ff    <= {byte_ff[6:0], 1'b0};
                           bit_cnt_ff <= bit_cnt_ff - 4'd1;
                        end else if (bit_w) begin
                           if (leaves_ff >= alpha_ff) begin
                              phase_ff <= hsd_pkg::PH_BAD;
                              state_ff <= S_BAD;
                           end else begin
                              leaf_pend_ff <= 4'd8;
                              byte_ff      <= {byte_ff[6:0], 1'b0};
                              bit_cnt_ff   <= bit_cnt_ff - 4'd1;
                           end
                        end else if (depth_ff < 9'd2) begin
                           phase_ff <= hsd_pkg::PH_BAD;
                           state_ff <= S_BAD;
                        end else begin
                           state_ff <= S_MERGE;
                        end
                     end
                     hsd_pkg::PH_DATA: begin
                        if (!root_ff.leaf) begin
                           bits_rem_ff <= bits_dec;
                           state_ff    <= S_WALK;
                        end else if (!pend_valid_ff || rsp_free) begin
                           // one-leaf tree: every code bit gives the root symbol
                           if (pend_valid_ff) begin
                              rsp_valid_ff     <= 1'b1;
                              rsp_symbol_ff    <= pend_sym_ff;
                              rsp_last_ff      <= 1'b0;
                              rsp_malformed_ff <= 1'b0;
                           end
                           pend_valid_ff <= 1'b1;
                           pend_sym_ff   <= root_ff.sym;
                           bits_rem_ff   <= bits_dec;
                           if (bits_dec == 32'd0) begin
                              phase_ff <= hsd_pkg::PH_DONE;
                           end
                           byte_ff    <= {byte_ff[6:0], 1'b0};
                           bit_cnt_ff <= bit_cnt_ff - 4'd1;
                        end
                     end
                     default: begin
                        state_ff <= S_FLUSH;
                     end
                  endcase
               end
            end
            S_MERGE: begin
               top_ff      <= node_cnt_ff;
               depth_ff    <= depth_m1;
               node_cnt_ff <= node_cnt_ff + IW'(1);
               root_ff     <= node_wdata;
               cur_ff      <= node_wdata;
               if (leaves_ff == alpha_ff && depth_m1 == 9'd1) begin
                  phase_ff <= (bits_rem_ff == 32'd0) ? hsd_pkg::PH_DONE
                                                     : hsd_pkg::PH_DATA;
               end
               byte_ff    <= {byte_ff[6:0], 1'b0};
               bit_cnt_ff <= bit_cnt_ff - 4'd1;
               state_ff   <= S_BIT;
            end
            S_WALK: begin
               if (!nv.leaf) begin
                  cur_ff <= nv;
               end
               if (!nv.leaf || !pend_valid_ff || rsp_free) begin
                  if (nv.leaf) begin
                     if (pend_valid_ff) begin
                        rsp_valid_ff     <= 1'b1;
                        rsp_symbol_ff    <= pend_sym_ff;
                        rsp_last_ff      <= 1'b0;
                        rsp_malformed_ff <= 1'b0;
                     end
                     pend_valid_ff <= 1'b1;
                     pend_sym_ff   <= nv.sym;
                     cur_ff        <= root_ff;
                  end
                  if (bits_rem_ff == 32'd0) begin
                     phase_ff <= hsd_pkg::PH_DONE;
                  end
                  byte_ff    <= {byte_ff[6:0], 1'b0};
                  bit_cnt_ff <= bit_cnt_ff - 4'd1;
                  state_ff   <= S_BIT;
               end
            end
            S_FLUSH: begin
               if (!pend_valid_ff) begin
                  state_ff <= S_IDLE;
               end else if (rsp_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_symbol_ff    <= pend_sym_ff;
                  rsp_last_ff      <= 1'b1;
                  rsp_malformed_ff <= 1'b0;
                  pend_valid_ff    <= 1'b0;
                  state_ff         <= S_IDLE;
               end
            end
            S_BAD: begin
               if (rsp_free) begin
                  rsp_valid_ff     <= 1'b1;
                  rsp_symbol_ff    <= 8'd0;
                  rsp_last_ff      <= 1'b1;
                  rsp_malformed_ff <= 1'b1;
                  state_ff         <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_symbol    = rsp_symbol_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_malformed = rsp_malformed_ff;

   // a malformed beat carries symbol zero and closes the input beat
   a_bad_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_malformed |-> rsp_symbol == 8'd0 && rsp_last)
      else $error("malformed beat with symbol or without last");

   // merges only start with two stack entries
   a_merge_depth: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MERGE |-> depth_ff >= 9'd2)
      else $error("merge with short stack");

   // no held symbol survives the end of a beat
   a_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !pend_valid_ff)
      else $error("held symbol while accepting");

   // leaf count never passes the alphabet size
   a_leaves: assert property (@(posedge clock) disable iff (reset)
      phase_ff == hsd_pkg::PH_TREE |-> leaves_ff <= alpha_ff)
      else $error("too many leaves stored");

endmodule
